/* hdl/stu_pkg.sv */
// ----------------------------------------------------------------------------
// stu_pkg
// Types and codes shared by the texture page unswizzler modules.
// ----------------------------------------------------------------------------
package stu_pkg;

  localparam logic [1:0] MODE_RGBA32 = 2'd0;
  localparam logic [1:0] MODE_RGBA16 = 2'd1;
  localparam logic [1:0] MODE_IDX8   = 2'd2;
  localparam logic [1:0] MODE_IDX4   = 2'd3;

  localparam logic [1:0] CFG_PIXEL_MODE   = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam int unsigned CoordW = 12;
  localparam int unsigned IdxW   = 13;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              in_image;
  } coord_t;

  typedef struct packed {
    logic       is_color;
    logic [7:0] palette_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } pix_t;

  typedef struct packed {
    coord_t coord;
    pix_t   pix;
  } result_t;

endpackage

/* hdl/swizzled_texture_unswizzle.sv */
// ----------------------------------------------------------------------------
// swizzled_texture_unswizzle
// Throughput: one item per cycle in 32-, 16- and 8-bit modes while the output
// does not stall; in 4-bit mode both pixels leave through one output port, so a
// new element waits while the second result slot holds a pixel.
// Reset: counter and page origin clear, mode 32-bit, width and height 64.
// ----------------------------------------------------------------------------
module swizzled_texture_unswizzle
  import stu_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] element_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] pixel_x_o,
  output logic [11:0] pixel_y_o,
  output logic        in_image_o,
  output logic        is_color_o,
  output logic [7:0]  palette_index_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic        last_o
);

  localparam logic [CoordW-1:0] MaxDim = CoordW'(MAX_DIMENSION);

  logic [1:0]        mode_q;
  logic [CoordW-1:0] width_q, height_q;
  logic [CoordW-1:0] width_eff, height_eff;

  logic              in_v_q, in_v_d;
  logic [31:0]       elem_q;
  logic              accept, advance, buf_ready;

  coord_t            coord0, coord1;
  pix_t              pix0, pix1;
  logic              dual;
  result_t           res0, res1;
  result_t           res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RGBA32;
      width_q  <= 12'd64;
      height_q <= 12'd64;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PIXEL_MODE:   mode_q   <= cfg_data_i[1:0];
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign width_eff  = (width_q > MaxDim) ? MaxDim : width_q;
  assign height_eff = (height_q > MaxDim) ? MaxDim : height_q;

  assign advance    = in_v_q && buf_ready;
  assign in_stall_o = in_v_q && !buf_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_v_d = in_v_q;
    if (accept) begin
      in_v_d = 1'b1;
    end else if (advance) begin
      in_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      elem_q <= element_i;
    end
  end

  stu_addr_gen u_addr_gen (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .mode_i   (mode_q),
    .width_i  (width_eff),
    .height_i (height_eff),
    .coord0_o (coord0),
    .coord1_o (coord1)
  );

  stu_pixel_fmt u_pixel_fmt (
    .mode_i    (mode_q),
    .element_i (elem_q),
    .pix0_o    (pix0),
    .pix1_o    (pix1),
    .dual_o    (dual)
  );

  assign res0 = '{coord: coord0, pix: pix0};
  assign res1 = '{coord: coord1, pix: pix1};

  stu_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .dual_i      (dual),
    .res0_i      (res0),
    .res1_i      (res1),
    .ready_o     (buf_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign pixel_x_o       = res.coord.x;
  assign pixel_y_o       = res.coord.y;
  assign in_image_o      = res.coord.in_image;
  assign is_color_o      = res.pix.is_color;
  assign palette_index_o = res.pix.palette_index;
  assign red_o           = res.pix.red;
  assign green_o         = res.pix.green;
  assign blue_o          = res.pix.blue;
  assign alpha_o         = res.pix.alpha;
  assign last_o          = res.pix.last;

  a_in_image_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_image_o |-> (pixel_x_o < MaxDim) && (pixel_y_o < MaxDim))
    else $error("pixel flagged in image beyond the dimension limit");

endmodule

/* hdl/stu_addr_gen.sv */
// ----------------------------------------------------------------------------
// stu_addr_gen
// Element counter and page origin; maps the counter to pixel coordinates.
// ----------------------------------------------------------------------------
module stu_addr_gen
  import stu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [1:0]        mode_i,
  input  logic [CoordW-1:0] width_i,
  input  logic [CoordW-1:0] height_i,
  output coord_t            coord0_o,
  output coord_t            coord1_o
);

  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CoordW-1:0] org_x_q, org_x_d;
  logic [CoordW-1:0] org_y_q, org_y_d;

  logic [6:0]        off_x, off_y;
  logic [7:0]        pw, ph;
  logic [IdxW:0]     count;
  logic              half;
  logic              page_end;
  logic [CoordW:0]   nx, ny;
  logic [CoordW-1:0] x0, y0, x1, y1;

  assign half = (width_i == 12'd64);

  always_comb begin
    case (mode_i)
      MODE_RGBA32: begin
        off_x = {1'b0, idx_q[5:0]};
        off_y = idx_q[12:6];
        pw    = 8'd64;
        ph    = 8'd32;
        count = 14'd2048;
      end
      MODE_RGBA16: begin
        off_x = {1'b0, idx_q[11:10], idx_q[0], idx_q[3:1]};
        off_y = {1'b0, idx_q[6:4], idx_q[9:7]};
        pw    = 8'd64;
        ph    = 8'd64;
        count = 14'd4096;
      end
      MODE_IDX8: begin
        off_x = {idx_q[7:5], idx_q[1], idx_q[4] ^ idx_q[0] ^ idx_q[9], idx_q[3:2]};
        off_y = {1'b0, idx_q[12:9], idx_q[0], idx_q[8]};
        pw    = 8'd128;
        ph    = 8'd64;
        count = half ? 14'd4096 : 14'd8192;
      end
      default: begin
        off_x = {idx_q[12:11], idx_q[1:0], idx_q[4] ^ idx_q[9], idx_q[3:2]};
        off_y = {idx_q[7:5], idx_q[10:9], 1'b0, idx_q[8]};
        pw    = 8'd128;
        ph    = 8'd128;
        count = half ? 14'd4096 : 14'd8192;
      end
    endcase
  end

  assign x0 = org_x_q + {5'd0, off_x};
  assign y0 = org_y_q + {5'd0, off_y};
  assign x1 = org_x_q + {5'd0, off_x ^ 7'd4};
  assign y1 = y0 + 12'd2;

  assign coord0_o = '{x: x0, y: y0, in_image: (x0 < width_i) && (y0 < height_i)};
  assign coord1_o = '{x: x1, y: y1, in_image: (x1 < width_i) && (y1 < height_i)};

  assign page_end = ({1'b0, idx_q} + 14'd1) >= count;
  assign nx       = {1'b0, org_x_q} + {5'd0, pw};
  assign ny       = {1'b0, org_y_q} + {5'd0, ph};

  always_comb begin
    idx_d   = idx_q;
    org_x_d = org_x_q;
    org_y_d = org_y_q;
    if (step_i) begin
      if (page_end) begin
        idx_d = '0;
        if (nx >= {1'b0, width_i}) begin
          org_x_d = '0;
          org_y_d = (ny >= {1'b0, height_i}) ? '0 : ny[CoordW-1:0];
        end else begin
          org_x_d = nx[CoordW-1:0];
        end
      end else begin
        idx_d = idx_q + 13'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      org_x_q <= '0;
      org_y_q <= '0;
    end else begin
      idx_q   <= idx_d;
      org_x_q <= org_x_d;
      org_y_q <= org_y_d;
    end
  end

  a_origin_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (org_x_q[5:0] == 6'd0) && (org_y_q[4:0] == 5'd0))
    else $error("page origin off page grid");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !page_end |=> idx_q == $past(idx_q) + 13'd1)
    else $error("element counter did not advance");

endmodule

/* hdl/stu_pixel_fmt.sv */
// ----------------------------------------------------------------------------
// stu_pixel_fmt
// Expands one element into pixel values for the active pixel mode.
// ----------------------------------------------------------------------------
module stu_pixel_fmt
  import stu_pkg::*;
(
  input  logic [1:0]  mode_i,
  input  logic [31:0] element_i,
  output pix_t        pix0_o,
  output pix_t        pix1_o,
  output logic        dual_o
);

  always_comb begin
    pix0_o = '0;
    pix1_o = '0;
    dual_o = 1'b0;
    case (mode_i)
      MODE_RGBA32: begin
        pix0_o.is_color = 1'b1;
        pix0_o.red      = element_i[7:0];
        pix0_o.green    = element_i[15:8];
        pix0_o.blue     = element_i[23:16];
        pix0_o.alpha    = element_i[31] ? 8'hff : {element_i[30:24], 1'b0};
        pix0_o.last     = 1'b1;
      end
      MODE_RGBA16: begin
        pix0_o.is_color = 1'b1;
        pix0_o.red      = {element_i[4:0], 3'b000};
        pix0_o.green    = {element_i[9:5], 3'b000};
        pix0_o.blue     = {element_i[14:10], 3'b000};
        pix0_o.alpha    = element_i[15] ? 8'hff : 8'h00;
        pix0_o.last     = 1'b1;
      end
      MODE_IDX8: begin
        pix0_o.palette_index = element_i[7:0];
        pix0_o.last          = 1'b1;
      end
      default: begin
        pix0_o.palette_index = {4'd0, element_i[3:0]};
        pix1_o.palette_index = {4'd0, element_i[7:4]};
        pix1_o.last          = 1'b1;
        dual_o               = 1'b1;
      end
    endcase
  end

endmodule

/* hdl/stu_out_buf.sv */
// ----------------------------------------------------------------------------
// stu_out_buf
// Result register with a second slot for the extra pixel of 4-bit elements.
// ----------------------------------------------------------------------------
module stu_out_buf
  import stu_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  logic    dual_i,
  input  result_t res0_i,
  input  result_t res1_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  logic    v0_q, v0_d, v1_q, v1_d;
  result_t r0_q, r1_q;
  logic    pop;

  assign pop         = v0_q && !out_stall_i;
  assign ready_o     = !v1_q && (!v0_q || pop);
  assign out_valid_o = v0_q;
  assign res_o       = r0_q;

  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    if (push_i) begin
      v0_d = 1'b1;
      v1_d = dual_i;
    end else if (pop) begin
      v0_d = v1_q;
      v1_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      r0_q <= res0_i;
      r1_q <= res1_i;
    end else if (pop && v1_q) begin
      r0_q <= r1_q;
    end
  end

  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> v0_q)
    else $error("second slot filled with first slot empty");

  a_pair_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q && !r0_q.pix.last |-> v1_q)
    else $error("first pixel of a pair shown without its partner");

endmodule
